// ----- hdl/rar_pkg.sv -----
// shared types and constants for the rational arithmetic reduce block
`default_nettype none
package rar_pkg;
    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int MAG_W = 64;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_COMB,
        ST_GCD_INIT,
        ST_GCD_EVEN,
        ST_GCD_UODD,
        ST_GCD_LOOP,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MUL1,
        CMD_MUL2,
        CMD_COMB,
        CMD_GCD_INIT,
        CMD_GCD_EVEN,
        CMD_GCD_UODD,
        CMD_GCD_STEP,
        CMD_DIVN_START,
        CMD_DIV_STEP,
        CMD_DIVD_START,
        CMD_OUT
    } cmd_t;

    typedef struct packed {
        logic err;
        logic both_even;
        logic u_even;
        logic v_zero;
        logic div_last;
    } status_t;
endpackage
`default_nettype wire

// ----- hdl/rational_arith_reduce_core.sv -----
// top level of the rational arithmetic reduce block
`default_nettype none
// Adds, subtracts, multiplies or divides two fractions and returns the result
// reduced to lowest terms with a positive denominator. One request is worked at
// a time: two products on the shared multiplier, a binary gcd taking one shift or
// subtract per cycle, then two restoring divisions by the gcd. A zero
// denominator, or division by a zero fraction, gives status 1 with 0/1. The
// result is held on m_ until taken.
module rational_arith_reduce_core
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // a_num[31:0], a_den[62:32], b_num[94:63], b_den[125:95], zero pad
    input  wire logic [127:0] s_tdata,
    // func[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // res_num[63:0], res_den[126:64], zero pad
    output logic [127:0]      m_tdata,
    // status[0]
    output logic              m_tuser
);
    cmd_t               cmd;
    status_t            stat;
    logic               busy;
    logic               mvalid_reg, mvalid_next;
    logic signed [63:0] res_num;
    logic [62:0]        res_den;
    logic               res_status;

    assign s_tready = aresetn && !busy;
    assign mvalid_next = (cmd == CMD_OUT) ? 1'b1 : (m_tready ? 1'b0 : mvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else begin
            mvalid_reg <= mvalid_next;
        end
    end

    rar_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_tvalid && aresetn),
        .out_free (!mvalid_reg || m_tready),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    rar_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .aclk       (aclk),
        .cmd        (cmd),
        .in_func    (s_tuser),
        .in_a_num   (s_tdata[31:0]),
        .in_a_den   (s_tdata[62:32]),
        .in_b_num   (s_tdata[94:63]),
        .in_b_den   (s_tdata[125:95]),
        .stat       (stat),
        .res_num    (res_num),
        .res_den    (res_den),
        .res_status (res_status)
    );

    logic [127:0] out_data_reg;
    logic         out_user_reg;
    always_ff @(posedge aclk) begin
        if (cmd == CMD_OUT) begin
            out_data_reg <= {1'b0, res_den, res_num};
            out_user_reg <= res_status;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    a_res_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[126:64] != '0)) else $error("zero denominator");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[63:0] == '0)) else $error("error result not zero");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == CMD_LOAD) |=> busy) else $error("busy not raised");
`endif
endmodule
`default_nettype wire

// ----- hdl/rar_ctrl.sv -----
// controller state machine sequencing products, gcd and the two divisions
`default_nettype none
module rar_ctrl
    import rar_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    start,
    input  wire logic    out_free,
    input  wire status_t stat,
    output cmd_t         cmd,
    output logic         busy
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    cmd        = CMD_LOAD;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: begin
                cmd        = CMD_MUL1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd        = CMD_MUL2;
                state_next = ST_COMB;
            end
            ST_COMB: begin
                cmd        = CMD_COMB;
                state_next = ST_GCD_INIT;
            end
            ST_GCD_INIT: begin
                cmd        = CMD_GCD_INIT;
                state_next = stat.err ? ST_DONE : ST_GCD_EVEN;
            end
            ST_GCD_EVEN: begin
                if (stat.both_even) begin
                    cmd = CMD_GCD_EVEN;
                end else begin
                    state_next = ST_GCD_UODD;
                end
            end
            ST_GCD_UODD: begin
                if (stat.u_even) begin
                    cmd = CMD_GCD_UODD;
                end else begin
                    state_next = ST_GCD_LOOP;
                end
            end
            ST_GCD_LOOP: begin
                if (stat.v_zero) begin
                    cmd        = CMD_DIVN_START;
                    state_next = ST_DIV_NUM;
                end else begin
                    cmd = CMD_GCD_STEP;
                end
            end
            ST_DIV_NUM: begin
                if (stat.div_last) begin
                    cmd        = CMD_DIVD_START;
                    state_next = ST_DIV_DEN;
                end else begin
                    cmd = CMD_DIV_STEP;
                end
            end
            ST_DIV_DEN: begin
                cmd = CMD_DIV_STEP;
                if (stat.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd        = CMD_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- hdl/rar_dp.sv -----
// datapath: operand registers, shared multiplier, binary gcd and restoring divider
`default_nettype none
module rar_dp
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  wire logic               aclk,
    input  wire cmd_t               cmd,
    input  wire logic [1:0]         in_func,
    input  wire logic signed [31:0] in_a_num,
    input  wire logic [30:0]        in_a_den,
    input  wire logic signed [31:0] in_b_num,
    input  wire logic [30:0]        in_b_den,
    output status_t                 stat,
    output logic signed [63:0]      res_num,
    output logic [62:0]             res_den,
    output logic                    res_status
);
    localparam int NW = OPERAND_WIDTH;
    localparam int DW = OPERAND_WIDTH - 1;
    localparam int CW = $clog2(MAG_W + 1);

    func_t                  func_reg;
    logic signed [NW-1:0]   an_reg, bn_reg;
    logic [DW-1:0]          ad_reg, bd_reg;
    logic signed [63:0]     p1_reg, p2_reg, den_reg;
    logic                   err_reg, neg_reg;
    logic [MAG_W-1:0]       u_reg, v_reg, mag_reg, uden_reg, g_reg;
    logic [CW-1:0]          shift_reg;
    logic [MAG_W-1:0]       q_reg, r_reg, dvd_reg;
    logic [CW-1:0]          cnt_reg;
    logic signed [63:0]     out_num_reg;
    logic [62:0]            out_den_reg;
    logic                   out_err_reg;

    logic signed [NW:0]     ma, mb;
    logic signed [2*NW+1:0] prod;
    logic [2*DW-1:0]        dprod;
    logic signed [63:0]     num_c, den_c;
    logic [MAG_W-1:0]       vs, uu, vv, r_sh, gcd_c;
    logic [MAG_W:0]         r_sub;

    always_comb begin
        ma = '0;
        mb = '0;
        if (cmd == CMD_MUL1) begin
            ma = (NW+1)'(an_reg);
            mb = (func_reg == FUNC_MUL) ? (NW+1)'(bn_reg) : (NW+1)'(signed'({1'b0, bd_reg}));
        end else begin
            ma = (func_reg == FUNC_DIV) ? (NW+1)'(signed'({1'b0, ad_reg})) : (NW+1)'(bn_reg);
            mb = (func_reg == FUNC_DIV) ? (NW+1)'(bn_reg) : (NW+1)'(signed'({1'b0, ad_reg}));
        end
        prod = ma * mb;
    end

    always_comb begin
        dprod = ad_reg * bd_reg;
        num_c = p1_reg;
        den_c = p2_reg;
        unique case (func_reg)
            FUNC_ADD: begin
                num_c = p1_reg + p2_reg;
                den_c = 64'(dprod);
            end
            FUNC_SUB: begin
                num_c = p1_reg - p2_reg;
                den_c = 64'(dprod);
            end
            FUNC_MUL: begin
                num_c = p1_reg;
                den_c = 64'(dprod);
            end
            FUNC_DIV: begin
                num_c = p1_reg;
                den_c = p2_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        vs = v_reg;
        if (!v_reg[0]) begin
            vs = v_reg >> 1;
        end
        uu = u_reg;
        vv = vs;
        if (u_reg > vs) begin
            uu = vs;
            vv = u_reg;
        end
        gcd_c = u_reg << shift_reg;
        r_sh  = {r_reg[MAG_W-2:0], dvd_reg[MAG_W-1]};
        r_sub = {1'b0, r_sh} - {1'b0, g_reg};
    end

    assign stat.err       = err_reg;
    assign stat.both_even = !u_reg[0] && !v_reg[0];
    assign stat.u_even    = !u_reg[0];
    assign stat.v_zero    = (v_reg == '0);
    assign stat.div_last  = (cnt_reg == CW'(MAG_W - 1));

    always_ff @(posedge aclk) begin
        unique case (cmd)
            CMD_LOAD: begin
                func_reg <= func_t'(in_func);
                an_reg   <= in_a_num[NW-1:0];
                bn_reg   <= in_b_num[NW-1:0];
                ad_reg   <= in_a_den[DW-1:0];
                bd_reg   <= in_b_den[DW-1:0];
            end
            CMD_MUL1: p1_reg <= 64'(prod);
            CMD_MUL2: p2_reg <= 64'(prod);
            CMD_COMB: begin
                err_reg <= (ad_reg == '0) || (bd_reg == '0)
                           || (func_reg == FUNC_DIV && bn_reg == '0);
                if (den_c < 0) begin
                    mag_reg <= -num_c;
                    neg_reg <= num_c > 0;
                    den_reg <= -den_c;
                end else begin
                    mag_reg <= num_c;
                    neg_reg <= num_c < 0;
                    den_reg <= den_c;
                end
            end
            CMD_GCD_INIT: begin
                if (neg_reg) begin
                    mag_reg <= -mag_reg;
                end
                uden_reg  <= den_reg;
                shift_reg <= '0;
                if (mag_reg == '0) begin
                    u_reg <= den_reg;
                    v_reg <= '0;
                end else begin
                    u_reg <= neg_reg ? -mag_reg : mag_reg;
                    v_reg <= den_reg;
                end
            end
            CMD_GCD_EVEN: begin
                u_reg     <= u_reg >> 1;
                v_reg     <= v_reg >> 1;
                shift_reg <= shift_reg + 1'b1;
            end
            CMD_GCD_UODD: u_reg <= u_reg >> 1;
            CMD_GCD_STEP: begin
                if (!v_reg[0]) begin
                    v_reg <= vs;
                end else begin
                    u_reg <= uu;
                    v_reg <= vv - uu;
                end
            end
            CMD_DIVN_START: begin
                g_reg   <= gcd_c;
                dvd_reg <= mag_reg;
                r_reg   <= '0;
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            CMD_DIV_STEP: begin
                dvd_reg <= dvd_reg << 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (!r_sub[MAG_W]) begin
                    r_reg <= r_sub[MAG_W-1:0];
                    q_reg <= {q_reg[MAG_W-2:0], 1'b1};
                end else begin
                    r_reg <= r_sh;
                    q_reg <= {q_reg[MAG_W-2:0], 1'b0};
                end
                if (stat.div_last) begin
                    out_err_reg <= 1'b0;
                    out_den_reg <= !r_sub[MAG_W] ? 63'({q_reg[MAG_W-2:0], 1'b1})
                                                 : 63'({q_reg[MAG_W-2:0], 1'b0});
                end
            end
            CMD_DIVD_START: begin
                out_num_reg <= neg_reg ? -signed'(!r_sub[MAG_W] ? {q_reg[MAG_W-2:0], 1'b1}
                                                               : {q_reg[MAG_W-2:0], 1'b0})
                                       : signed'(!r_sub[MAG_W] ? {q_reg[MAG_W-2:0], 1'b1}
                                                               : {q_reg[MAG_W-2:0], 1'b0});
                dvd_reg <= uden_reg;
                r_reg   <= '0;
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            default: ;
        endcase
        if (cmd == CMD_GCD_INIT && err_reg) begin
            out_num_reg <= '0;
            out_den_reg <= 63'd1;
            out_err_reg <= 1'b1;
        end
    end

    assign res_num    = out_num_reg;
    assign res_den    = out_den_reg;
    assign res_status = out_err_reg;
endmodule
`default_nettype wire
